[rtl/core/naive_bayes_pixel_classifier_defines.svh]
// ----------------------------------------------------------------------------
// Naive Bayes pixel classifier assertion macros
// Shared assertion forms for the classifier checkers.
// ----------------------------------------------------------------------------
`ifndef NAIVE_BAYES_PIXEL_CLASSIFIER_DEFINES_SVH
`define NAIVE_BAYES_PIXEL_CLASSIFIER_DEFINES_SVH

// check in the same cycle
`define NBPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check in the next cycle
`define NBPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/nbpc_pkg.sv]
// ----------------------------------------------------------------------------
// Naive Bayes pixel classifier package
// Commands, sequencer states and fixed-point constants.
// ----------------------------------------------------------------------------
package nbpc_pkg;

  localparam int unsigned SHADE_LEVELS = 2;
  localparam int unsigned LOG_W        = 22;
  localparam int unsigned SCORE_W      = 32;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_LOAD_LIK   = 2'd0,
    CMD_LOAD_PRIOR = 2'd1,
    CMD_CLASSIFY   = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_FINAL,
    ST_EMIT
  } state_e;

endpackage

[rtl/core/nbpc_ram.sv]
// ----------------------------------------------------------------------------
// Naive Bayes pixel classifier RAM
// Generic single write port, single registered read port memory.
// ----------------------------------------------------------------------------
module nbpc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/naive_bayes_pixel_classifier.sv]
// ----------------------------------------------------------------------------
// Naive Bayes pixel classifier
// Bernoulli naive Bayes scoring of binary images from loaded log tables.
// ----------------------------------------------------------------------------
// Usage: one command channel. An item is taken when start is high and busy
// is low. Command 0 writes one Q5.16 log likelihood entry, command 1 writes
// one class log prior; neither raises busy.
// Command 2 carries one pixel. A shared saturating adder walks the classes,
// one class per cycle from the likelihood memory, while busy stays high.
// A pixel outside the image adds nothing; unless marked last it does not raise busy.
// On the pixel marked last the same adder then adds each prior and compares,
// again one class per cycle, with busy high throughout (a last pixel outside
// the image skips the likelihood pass); the result (class and score) shows
// on the result ports for one cycle with valid_o high, in the first cycle
// with busy low again, and the class scores restart at zero.
// The receiver cannot stall; a result is shown once and is gone.
// Reset: class scores read as zero, the likelihood and prior memories are
// undefined until written and get no clearing pass.
// ----------------------------------------------------------------------------
module naive_bayes_pixel_classifier #(
  parameter int unsigned NUM_CLASSES = 10,
  parameter int unsigned IMAGE_SIDE  = 28
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command_i,
  input  logic [3:0]                   class_index_i,
  input  logic [9:0]                   pixel_index_i,
  input  logic                         shade_i,
  input  logic signed [21:0]           log_value_i,
  input  logic                         last_pixel_i,
  output logic                         valid_o,
  output logic [3:0]                   predicted_class_o,
  output logic signed [31:0]           best_score_o
);

  localparam int unsigned PIXELS    = IMAGE_SIDE * IMAGE_SIDE;
  localparam int unsigned LIK_DEPTH = NUM_CLASSES * PIXELS * nbpc_pkg::SHADE_LEVELS;
  localparam int unsigned LIK_AW    = $clog2(LIK_DEPTH);
  localparam int unsigned CLS_W     = $clog2(NUM_CLASSES);
  localparam int unsigned ROW_STEP  = PIXELS * nbpc_pkg::SHADE_LEVELS;

  nbpc_pkg::state_e state_q, state_d;

  logic                 accept;
  logic                 cls_ok;
  logic                 pix_ok;
  logic                 lik_we;
  logic                 prior_we;
  logic [LIK_AW-1:0]    lik_waddr;
  logic [LIK_AW-1:0]    lik_raddr;
  logic [21:0]          lik_rdata;
  logic [21:0]          prior_rdata;
  logic [31:0]          score_rdata;

  logic [9:0]           pix_q;
  logic                 shade_q;
  logic                 last_q;
  logic [LIK_AW-1:0]    base_q, base_d;
  logic [CLS_W-1:0]     cnt_q, cnt_d;
  logic                 cnt_last;

  logic                 stg_vld_q, stg_vld_d;
  logic                 stg_fin_q, stg_fin_d;
  logic [CLS_W-1:0]     stg_cls_q;

  logic [NUM_CLASSES-1:0] score_vld_q;
  logic                 run;
  logic                 emit;

  logic signed [31:0]   add_a;
  logic signed [21:0]   add_b;
  logic signed [32:0]   sum;
  logic signed [31:0]   sat;
  logic                 score_we;
  logic                 take;

  logic signed [31:0]   best_q, best_d;
  logic [CLS_W-1:0]     best_cls_q, best_cls_d;
  logic                 valid_q;
  logic [3:0]           out_cls_q;
  logic signed [31:0]   out_score_q;

  assign accept   = start && !busy;
  assign cls_ok   = 32'(class_index_i) < NUM_CLASSES;
  assign pix_ok   = 32'(pixel_index_i) < PIXELS;
  assign lik_we   = accept && (command_i == nbpc_pkg::CMD_LOAD_LIK) && cls_ok && pix_ok;
  assign prior_we = accept && (command_i == nbpc_pkg::CMD_LOAD_PRIOR) && cls_ok;
  assign lik_waddr = LIK_AW'(32'(class_index_i) * ROW_STEP + 32'({pixel_index_i, shade_i}));
  assign lik_raddr = base_q + LIK_AW'({pix_q, shade_q});
  assign cnt_last  = cnt_q == CLS_W'(NUM_CLASSES - 1);

  nbpc_ram #(.WIDTH(nbpc_pkg::LOG_W), .DEPTH(LIK_DEPTH)) u_lik_ram (
    .clk_i   (clk_i),
    .we_i    (lik_we),
    .waddr_i (lik_waddr),
    .wdata_i (log_value_i),
    .raddr_i (lik_raddr),
    .rdata_o (lik_rdata)
  );

  nbpc_ram #(.WIDTH(nbpc_pkg::LOG_W), .DEPTH(NUM_CLASSES)) u_prior_ram (
    .clk_i   (clk_i),
    .we_i    (prior_we),
    .waddr_i (CLS_W'(class_index_i)),
    .wdata_i (log_value_i),
    .raddr_i (cnt_q),
    .rdata_o (prior_rdata)
  );

  nbpc_ram #(.WIDTH(nbpc_pkg::SCORE_W), .DEPTH(NUM_CLASSES)) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (score_we),
    .waddr_i (stg_cls_q),
    .wdata_i (sat),
    .raddr_i (cnt_q),
    .rdata_o (score_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      nbpc_pkg::ST_IDLE: begin
        if (accept && (command_i == nbpc_pkg::CMD_CLASSIFY)) begin
          if (pix_ok) begin
            state_d = nbpc_pkg::ST_ACCUM;
          end else if (last_pixel_i) begin
            state_d = nbpc_pkg::ST_FINAL;
          end
        end
      end
      nbpc_pkg::ST_ACCUM: begin
        if (cnt_last) begin
          state_d = last_q ? nbpc_pkg::ST_FINAL : nbpc_pkg::ST_IDLE;
        end
      end
      nbpc_pkg::ST_FINAL: begin
        if (cnt_last) begin
          state_d = nbpc_pkg::ST_EMIT;
        end
      end
      nbpc_pkg::ST_EMIT: state_d = nbpc_pkg::ST_IDLE;
      default:           state_d = nbpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    run       = 1'b0;
    stg_fin_d = 1'b0;
    emit      = 1'b0;
    case (state_q)
      nbpc_pkg::ST_IDLE:  busy = 1'b0;
      nbpc_pkg::ST_ACCUM: run  = 1'b1;
      nbpc_pkg::ST_FINAL: begin
        run       = 1'b1;
        stg_fin_d = 1'b1;
      end
      nbpc_pkg::ST_EMIT:  emit = 1'b1;
      default:            busy = 1'b0;
    endcase
  end

  assign stg_vld_d = run;
  assign cnt_d     = (!run || cnt_last) ? '0 : cnt_q + 1'b1;
  assign base_d    = accept ? '0 : (run ? base_q + LIK_AW'(ROW_STEP) : base_q);

  assign add_a = score_vld_q[stg_cls_q] ? $signed(score_rdata) : '0;
  assign add_b = stg_fin_q ? $signed(prior_rdata) : $signed(lik_rdata);
  assign sum   = {add_a[31], add_a} + 33'(add_b);

  always_comb begin
    sat = sum[31:0];
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? nbpc_pkg::SCORE_MIN : nbpc_pkg::SCORE_MAX;
    end
  end

  assign score_we = stg_vld_q && !stg_fin_q;
  assign take     = stg_vld_q && stg_fin_q && ((stg_cls_q == '0) || (sat > best_q));

  always_comb begin
    best_d     = best_q;
    best_cls_d = best_cls_q;
    if (take) begin
      best_d     = sat;
      best_cls_d = stg_cls_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nbpc_pkg::ST_IDLE;
      cnt_q       <= '0;
      base_q      <= '0;
      stg_vld_q   <= 1'b0;
      stg_fin_q   <= 1'b0;
      score_vld_q <= '0;
      valid_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      base_q    <= base_d;
      stg_vld_q <= stg_vld_d;
      stg_fin_q <= stg_fin_d;
      valid_q   <= emit;
      if (emit) begin
        score_vld_q <= '0;
      end else if (score_we) begin
        score_vld_q[stg_cls_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stg_cls_q  <= cnt_q;
    best_q     <= best_d;
    best_cls_q <= best_cls_d;
    if (accept && (command_i == nbpc_pkg::CMD_CLASSIFY)) begin
      pix_q   <= pixel_index_i;
      shade_q <= shade_i;
      last_q  <= last_pixel_i;
    end
    if (emit) begin
      out_cls_q   <= 4'(best_cls_d);
      out_score_q <= best_d;
    end
  end

  assign valid_o           = valid_q;
  assign predicted_class_o = out_cls_q;
  assign best_score_o      = out_score_q;

endmodule

[rtl/core/nbpc_checker.sv]
// ----------------------------------------------------------------------------
// Naive Bayes pixel classifier checker
// Port-level checks of the command and result sequencing.
// ----------------------------------------------------------------------------
`include "naive_bayes_pixel_classifier_defines.svh"

module nbpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] command_i,
  input logic       valid_o
);

  `NBPC_ASSERT_NOW(a_result_idle, valid_o, !busy && $past(busy), "result outside idle")
  `NBPC_ASSERT_NEXT(a_result_single, valid_o, !valid_o, "result repeated")
  `NBPC_ASSERT_NEXT(a_load_no_busy, start && !busy && (command_i != nbpc_pkg::CMD_CLASSIFY), !busy, "load raised busy")
  `NBPC_ASSERT_NOW(a_busy_cause, $rose(busy), $past(start) && ($past(command_i) == nbpc_pkg::CMD_CLASSIFY), "busy without pixel item")

endmodule

bind naive_bayes_pixel_classifier nbpc_checker u_nbpc_checker (.*);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Naive Bayes pixel classifier testbench
// Loads log priors and likelihoods, then runs a short table of directed items
// and random images with noise between them. Results are compared with typed
// values or with a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned NUM_CLASSES     = 10;
  localparam int unsigned IMAGE_SIDE      = 28;
  localparam int unsigned PIXELS          = IMAGE_SIDE * IMAGE_SIDE;
  localparam int unsigned LIK_DEPTH       = NUM_CLASSES * PIXELS * nbpc_pkg::SHADE_LEVELS;
  localparam int unsigned RANDOM_ITEMS    = 800;
  localparam int unsigned STALL_LIMIT     = 1000;
  localparam int unsigned DRAIN_CYCLES    = 2 * NUM_CLASSES + 8;
  localparam int unsigned MAX_REPORTS     = 40;
  localparam int unsigned LOG_W           = nbpc_pkg::LOG_W;
  localparam int unsigned SCORE_W         = nbpc_pkg::SCORE_W;

  localparam logic signed [LOG_W-1:0] LOG_MIN = {1'b1, {(LOG_W-1){1'b0}}};
  localparam logic signed [LOG_W-1:0] LOG_MAX = {1'b0, {(LOG_W-1){1'b1}}};

  typedef struct {
    logic [3:0]                cls;
    logic signed [SCORE_W-1:0] score;
  } winner_t;

  typedef struct {
    nbpc_pkg::cmd_e            cmd;
    logic [3:0]                cls;
    logic [9:0]                pix;
    logic                      shade;
    logic signed [LOG_W-1:0]   value;
    logic                      last;
    bit                        typed;
    logic [3:0]                exp_cls;
    logic signed [SCORE_W-1:0] exp_score;
  } stim_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [1:0]                command_i;
  logic [3:0]                class_index_i;
  logic [9:0]                pixel_index_i;
  logic                      shade_i;
  logic signed [LOG_W-1:0]   log_value_i;
  logic                      last_pixel_i;
  logic                      valid_o;
  logic [3:0]                predicted_class_o;
  logic signed [SCORE_W-1:0] best_score_o;

  logic signed [LOG_W-1:0]   lik_mem     [LIK_DEPTH];
  bit                        lik_written [LIK_DEPTH];
  logic signed [LOG_W-1:0]   prior_mem   [NUM_CLASSES];
  logic signed [SCORE_W-1:0] class_acc   [NUM_CLASSES];

  winner_t     expected_winners [$];
  winner_t     head;
  int unsigned pool [$];
  int unsigned idle_pct;
  int unsigned errors;
  int unsigned stall_cnt;

  stim_row_t directed_rows [23] = '{
    '{nbpc_pkg::CMD_CLASSIFY,   4'd0,  10'd1000, 1'b0, 22'sd0,  1'b1, 1'b1, 4'd0, -32'sd65536},
    '{nbpc_pkg::CMD_LOAD_PRIOR, 4'd7,  10'd1023, 1'b1, 22'sd0,  1'b1, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_CLASSIFY,   4'd15, 10'd784,  1'b1, LOG_MAX, 1'b1, 1'b1, 4'd7, 32'sd0},
    '{nbpc_pkg::CMD_LOAD_PRIOR, 4'd15, 10'd0,    1'b0, LOG_MAX, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_CLASSIFY,   4'd0,  10'd1023, 1'b1, 22'sd0,  1'b1, 1'b1, 4'd7, 32'sd0},
    '{nbpc_pkg::CMD_LOAD_PRIOR, 4'd9,  10'd0,    1'b0, LOG_MAX, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_CLASSIFY,   4'd0,  10'd900,  1'b0, 22'sd0,  1'b1, 1'b1, 4'd9, 32'sd2097151},
    '{nbpc_pkg::CMD_LOAD_PRIOR, 4'd9,  10'd0,    1'b0, LOG_MIN, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_LOAD_PRIOR, 4'd0,  10'd0,    1'b0, 22'sd0,  1'b0, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_CLASSIFY,   4'd0,  10'd784,  1'b0, 22'sd0,  1'b1, 1'b1, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_NONE,       4'd15, 10'd0,    1'b1, LOG_MIN, 1'b1, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_LOAD_LIK,   4'd10, 10'd0,    1'b0, LOG_MAX, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_LOAD_LIK,   4'd0,  10'd784,  1'b0, LOG_MAX, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_LOAD_LIK,   4'd15, 10'd1023, 1'b1, LOG_MAX, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_LOAD_LIK,   4'd2,  10'd0,    1'b1, LOG_MAX, 1'b1, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_LOAD_LIK,   4'd9,  10'd783,  1'b0, LOG_MIN, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_CLASSIFY,   4'd0,  10'd0,    1'b1, 22'sd0,  1'b0, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_CLASSIFY,   4'd0,  10'd783,  1'b0, 22'sd0,  1'b0, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_CLASSIFY,   4'd0,  10'd800,  1'b1, 22'sd0,  1'b0, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_CLASSIFY,   4'd0,  10'd783,  1'b1, 22'sd0,  1'b1, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_CLASSIFY,   4'd0,  10'd0,    1'b0, 22'sd0,  1'b1, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_LOAD_PRIOR, 4'd3,  10'd5,    1'b1, -22'sd1, 1'b1, 1'b0, 4'd0, 32'sd0},
    '{nbpc_pkg::CMD_CLASSIFY,   4'd0,  10'd391,  1'b1, 22'sd0,  1'b1, 1'b0, 4'd0, 32'sd0}
  };

  naive_bayes_pixel_classifier #(
    .NUM_CLASSES(NUM_CLASSES),
    .IMAGE_SIDE (IMAGE_SIDE)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .class_index_i    (class_index_i),
    .pixel_index_i    (pixel_index_i),
    .shade_i          (shade_i),
    .log_value_i      (log_value_i),
    .last_pixel_i     (last_pixel_i),
    .valid_o          (valid_o),
    .predicted_class_o(predicted_class_o),
    .best_score_o     (best_score_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned lik_addr(int unsigned cls, int unsigned pix,
                                           int unsigned shade);
    return (cls * PIXELS + pix) * nbpc_pkg::SHADE_LEVELS + shade;
  endfunction

  function automatic logic signed [SCORE_W-1:0] saturating_add(
      logic signed [SCORE_W-1:0] acc, logic signed [LOG_W-1:0] term);
    logic [SCORE_W:0] sum;
    sum = {acc[SCORE_W-1], acc} + {{(SCORE_W-LOG_W+1){term[LOG_W-1]}}, term};
    case (sum[SCORE_W:SCORE_W-1])
      2'b10:   return nbpc_pkg::SCORE_MIN;
      2'b01:   return nbpc_pkg::SCORE_MAX;
      default: return sum[SCORE_W-1:0];
    endcase
  endfunction

  function automatic bit entry_ready(int unsigned pix, int unsigned shade);
    for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
      if (!lik_written[lik_addr(c, pix, shade)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [LOG_W-1:0] rand_log();
    int unsigned pick;
    pick = $urandom_range(9);
    case (pick)
      0:       return LOG_MIN;
      1:       return LOG_MAX;
      2:       return '0;
      3, 4:    return LOG_W'($urandom);
      default: return LOG_W'(0 - $urandom_range(2097152, 0));
    endcase
  endfunction

  function automatic stim_row_t make_row(nbpc_pkg::cmd_e cmd, int unsigned cls,
                                         int unsigned pix, int unsigned shade,
                                         logic signed [LOG_W-1:0] value,
                                         int unsigned last);
    stim_row_t row;
    row.cmd       = cmd;
    row.cls       = 4'(cls);
    row.pix       = 10'(pix);
    row.shade     = 1'(shade);
    row.value     = value;
    row.last      = 1'(last);
    row.typed     = 1'b0;
    row.exp_cls   = '0;
    row.exp_score = '0;
    return row;
  endfunction

  task automatic predict_posterior(input stim_row_t row, output bit emits,
                                   output winner_t win);
    logic signed [SCORE_W-1:0] total;
    int unsigned               addr;
    emits     = 1'b0;
    win.cls   = '0;
    win.score = '0;
    addr      = lik_addr(32'(row.cls), 32'(row.pix), 32'(row.shade));
    case (row.cmd)
      nbpc_pkg::CMD_LOAD_LIK: begin
        if (row.cls < NUM_CLASSES && row.pix < PIXELS) begin
          lik_mem[addr]     = row.value;
          lik_written[addr] = 1'b1;
        end
      end
      nbpc_pkg::CMD_LOAD_PRIOR: begin
        if (row.cls < NUM_CLASSES) prior_mem[row.cls] = row.value;
      end
      nbpc_pkg::CMD_CLASSIFY: begin
        if (row.pix < PIXELS) begin
          for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
            class_acc[c] = saturating_add(class_acc[c],
                                          lik_mem[lik_addr(c, 32'(row.pix), 32'(row.shade))]);
          end
        end
        if (row.last) begin
          for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
            total = saturating_add(class_acc[c], prior_mem[c]);
            if (c == 0 || total > win.score) begin
              win.score = total;
              win.cls   = 4'(c);
            end
            class_acc[c] = '0;
          end
          emits = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input stim_row_t row);
    bit      emits;
    winner_t win;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start         <= 1'b1;
    command_i     <= row.cmd;
    class_index_i <= row.cls;
    pixel_index_i <= row.pix;
    shade_i       <= row.shade;
    log_value_i   <= row.value;
    last_pixel_i  <= row.last;
    do @(posedge clk_i); while (busy);
    predict_posterior(row, emits, win);
    if (emits) begin
      if (row.typed) begin
        win.cls   = row.exp_cls;
        win.score = row.exp_score;
      end
      expected_winners.push_back(win);
    end
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_winners.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string field,
                                 input logic signed [SCORE_W-1:0] exp,
                                 input logic signed [SCORE_W-1:0] act);
    errors++;
    if (errors <= MAX_REPORTS) $error("%s: expected %0d, actual %0d", field, exp, act);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cnt <= 0;
    end else begin
      if ((start && !busy) || valid_o) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (valid_o) begin
        if (expected_winners.size() == 0) begin
          report_mismatch("unexpected result, best_score", '0, best_score_o);
        end else begin
          head = expected_winners.pop_front();
          if (predicted_class_o !== head.cls)
            report_mismatch("predicted_class", SCORE_W'(head.cls),
                            SCORE_W'(predicted_class_o));
          if (best_score_o !== head.score)
            report_mismatch("best_score", head.score, best_score_o);
        end
      end
    end
  end

  initial begin
    wait (stall_cnt >= STALL_LIMIT);
    $display("FAIL naive_bayes_pixel_classifier");
    $finish;
  end

  initial begin
    stim_row_t   row;
    int unsigned len;
    int unsigned pix;
    int unsigned shade;
    int unsigned kind;
    int unsigned sent;
    rst_ni        = 1'b0;
    start         = 1'b0;
    command_i     = nbpc_pkg::CMD_NONE;
    class_index_i = '0;
    pixel_index_i = '0;
    shade_i       = 1'b0;
    log_value_i   = '0;
    last_pixel_i  = 1'b0;
    errors        = 0;
    idle_pct      = 16;
    for (int c = 0; c < NUM_CLASSES; c++) class_acc[c] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    pool = '{0, 1, 2, 391, 781, 782, 783};
    for (int unsigned c = 0; c < NUM_CLASSES; c++)
      send_item(make_row(nbpc_pkg::CMD_LOAD_PRIOR, c, 0, 0, -22'sd65536, 0));
    foreach (pool[i]) begin
      for (int unsigned s = 0; s < nbpc_pkg::SHADE_LEVELS; s++) begin
        for (int unsigned c = 0; c < NUM_CLASSES; c++)
          send_item(make_row(nbpc_pkg::CMD_LOAD_LIK, c, pool[i], s, rand_log(), 0));
      end
    end

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    pause_until_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_pct = (sent < RANDOM_ITEMS / 3) ? 16 : (sent < 2 * RANDOM_ITEMS / 3) ? 51 : 0;
      if ($urandom_range(99) < 12) begin
        kind = $urandom_range(3);
        case (kind)
          0: row = make_row(nbpc_pkg::CMD_LOAD_LIK, $urandom_range(NUM_CLASSES - 1),
                            pool[$urandom_range(pool.size() - 1)], $urandom_range(1),
                            rand_log(), $urandom_range(1));
          1: row = make_row(nbpc_pkg::CMD_LOAD_LIK, $urandom_range(NUM_CLASSES - 1),
                            $urandom_range(PIXELS - 1), $urandom_range(1),
                            rand_log(), $urandom_range(1));
          2: row = make_row(nbpc_pkg::CMD_LOAD_PRIOR, $urandom_range(NUM_CLASSES - 1),
                            $urandom_range(1023), $urandom_range(1),
                            rand_log(), $urandom_range(1));
          default: begin
            case ($urandom_range(3))
              0: row = make_row(nbpc_pkg::CMD_NONE, $urandom_range(15),
                                $urandom_range(1023), $urandom_range(1), rand_log(),
                                $urandom_range(1));
              1: row = make_row(nbpc_pkg::CMD_LOAD_LIK, $urandom_range(15, NUM_CLASSES),
                                $urandom_range(1023), $urandom_range(1),
                                rand_log(), $urandom_range(1));
              2: row = make_row(nbpc_pkg::CMD_LOAD_LIK, $urandom_range(NUM_CLASSES - 1),
                                $urandom_range(1023, PIXELS), $urandom_range(1),
                                rand_log(), $urandom_range(1));
              default: row = make_row(nbpc_pkg::CMD_LOAD_PRIOR,
                                      $urandom_range(15, NUM_CLASSES),
                                      $urandom_range(1023), $urandom_range(1),
                                      rand_log(), $urandom_range(1));
            endcase
          end
        endcase
        send_item(row);
        if (kind < 3) sent++;
      end else begin
        len = $urandom_range(24, 1);
        for (int unsigned i = 0; i < len; i++) begin
          pix   = $urandom_range(1023);
          shade = $urandom_range(1);
          if (pix < PIXELS && !entry_ready(pix, shade))
            pix = pool[$urandom_range(pool.size() - 1)];
          send_item(make_row(nbpc_pkg::CMD_CLASSIFY, $urandom_range(15), pix, shade,
                             LOG_W'($urandom),
                             32'((i == len - 1) && ($urandom_range(99) >= 10))));
          sent++;
        end
      end
    end

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("PASS naive_bayes_pixel_classifier");
    else $display("FAIL naive_bayes_pixel_classifier");
    $finish;
  end

endmodule
